/* rtl/tcs_pkg.sv */
// ----------------------------------------------------------------------------
// tcs_pkg: shared constants and types for the touch calibrate and smooth unit
// Field widths, register indexes, register reset values, lane status word.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int RAW_W      = 12;
  localparam int RES_W      = 12;
  localparam int POS_W      = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int PROD_W     = RAW_W + RES_W;
  localparam int COORD_BITS_DEF = 12;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROTATE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_X_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_X_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAL_Y_MAX  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H   = 3'd7;

  // register reset values
  localparam logic             RST_ENABLE    = 1'b1;
  localparam logic             RST_ROTATE    = 1'b1;
  localparam logic [RAW_W-1:0] RST_CAL_MIN   = 12'd200;
  localparam logic [RAW_W-1:0] RST_CAL_MAX   = 12'd3900;
  localparam logic [RES_W-1:0] RST_SCREEN_W  = 12'd320;
  localparam logic [RES_W-1:0] RST_SCREEN_H  = 12'd240;

  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] coord;
  } tcs_lane_status_t;

endpackage

/* rtl/tcs_lane.sv */
// ----------------------------------------------------------------------------
// tcs_lane: one axis of the calibration map
// Multiplies the window offset by the resolution, divides by the window span
// one quotient bit per cycle, restores the sign, offsets and clamps.
// ----------------------------------------------------------------------------
module tcs_lane
  import tcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RAW_W-1:0] raw,
  input  logic [RAW_W-1:0] lo,
  input  logic [RAW_W-1:0] hi,
  input  logic [RES_W-1:0] res,
  output tcs_lane_status_t status
);

  localparam int CNT_W = $clog2(PROD_W);
  localparam int M_W   = PROD_W + 2;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PROD_W - 1);

  logic                busy_r, busy_nxt;
  logic                fin_r, fin_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [PROD_W-1:0]   dq_r;
  logic [RAW_W-1:0]    rem_r;
  logic [RAW_W-1:0]    dvs_r;
  logic                neg_r;
  logic                zero_r;
  logic [RES_W-1:0]    res_r;
  logic [POS_W-1:0]    coord_r;

  logic [RAW_W:0]      diff;
  logic [RAW_W:0]      span;
  logic [RAW_W:0]      diff_abs;
  logic [RAW_W:0]      span_abs;
  logic [PROD_W-1:0]   prod;
  logic [RAW_W:0]      trial;
  logic [RAW_W:0]      trial_sub;
  logic                trial_ge;
  logic [M_W-1:0]      res_s;
  logic [M_W-1:0]      quo_s;
  logic [M_W-1:0]      m_val;
  logic [POS_W-1:0]    coord_nxt;

  always_comb begin
    diff     = {1'b0, raw} - {1'b0, lo};
    span     = {1'b0, hi} - {1'b0, lo};
    diff_abs = diff[RAW_W] ? (~diff + 1'b1) : diff;
    span_abs = span[RAW_W] ? (~span + 1'b1) : span;
    prod     = PROD_W'(diff_abs[RAW_W-1:0]) * PROD_W'(res);
  end

  // restoring divide step
  always_comb begin
    trial     = {rem_r, dq_r[PROD_W-1]};
    trial_sub = trial - {1'b0, dvs_r};
    trial_ge  = (trial >= {1'b0, dvs_r});
  end

  // sign, offset by resolution, clamp to 0..res-1
  always_comb begin
    res_s = M_W'(res_r);
    quo_s = M_W'(dq_r);
    m_val = neg_r ? (res_s - quo_s) : (res_s + quo_s);
    if (zero_r) begin
      coord_nxt = '0;
    end else if (m_val[M_W-1]) begin
      coord_nxt = '0;
    end else if (m_val >= res_s) begin
      coord_nxt = res_r - 1'b1;
    end else begin
      coord_nxt = m_val[POS_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
    if (fin_r) begin
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r   <= prod;
      rem_r  <= '0;
      dvs_r  <= span_abs[RAW_W-1:0];
      // quotient is negative when offset is positive, flipped by a reversed window
      neg_r  <= ~diff[RAW_W] ^ span[RAW_W];
      zero_r <= (span == '0) || (res == '0);
      res_r  <= res;
    end else if (busy_r) begin
      dq_r  <= {dq_r[PROD_W-2:0], trial_ge};
      rem_r <= trial_ge ? trial_sub[RAW_W-1:0] : trial[RAW_W-1:0];
    end
    if (fin_r) begin
      coord_r <= coord_nxt;
    end
  end

  assign status.done  = done_r;
  assign status.coord = coord_r;

endmodule

/* rtl/touch_coordinate_calibrate_smooth_unit.sv */
// ----------------------------------------------------------------------------
// touch_coordinate_calibrate_smooth_unit: touch calibration with smoothing
// Maps raw X and Y through their calibration windows in two parallel lanes,
// then mirrors Y if asked and runs the 3/4 old plus 1/4 new low-pass filter.
// ----------------------------------------------------------------------------
// a pressed, enabled word passes the start, divide and merge states; the divide
//   phase is set by the 24-step bit-serial divider in each lane
// released or disabled words bypass the lanes and go straight to merge; no new
//   word is taken until the current one has left the merge state
// a finished result waits in the output register while the next word is taken
// reset (synchronous, rst_n low): registers to defaults, filter empty, idle
module touch_coordinate_calibrate_smooth_unit
  import tcs_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_pressed,
  input  logic [RAW_W-1:0]      in_raw_x,
  input  logic [RAW_W-1:0]      in_raw_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_touch_valid,
  output logic [POS_W-1:0]      out_pos_x,
  output logic [POS_W-1:0]      out_pos_y,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WIDE_W = (COORD_BITS > POS_W) ? COORD_BITS : POS_W;
  localparam int SUM_W  = WIDE_W + 2;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_START = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_MERGE = 2'd3;

  logic [1:0]            state_r, state_nxt;

  logic                  cfg_enable_r;
  logic                  cfg_rotate_r;
  logic [RAW_W-1:0]      cfg_x_min_r, cfg_x_max_r, cfg_y_min_r, cfg_y_max_r;
  logic [RES_W-1:0]      cfg_width_r, cfg_height_r;

  logic [RAW_W-1:0]      raw_x_r, raw_y_r;
  logic                  pressed_r;
  logic                  en_r;

  logic [COORD_BITS-1:0] smooth_x_r, smooth_x_nxt;
  logic [COORD_BITS-1:0] smooth_y_r, smooth_y_nxt;
  logic                  primed_r, primed_nxt;

  logic                  out_valid_r;
  logic                  out_tv_r;
  logic [POS_W-1:0]      out_x_r, out_y_r;

  tcs_lane_status_t      lane_x_st, lane_y_st;

  logic                  accept;
  logic                  out_free;
  logic                  merge_fire;
  logic                  lane_start;
  logic [POS_W-1:0]      y_rot;
  logic [SUM_W-1:0]      sum_x, sum_y;
  logic [WIDE_W-1:0]     seed_x_w, seed_y_w;
  logic [WIDE_W-1:0]     filt_x_w, filt_y_w;
  logic [WIDE_W-1:0]     pos_x_w, pos_y_w;

  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign merge_fire = (state_r == S_MERGE) && out_free;
  assign lane_start = (state_r == S_START);
  assign in_ready   = (state_r == S_IDLE);

  tcs_lane u_lane_x (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .raw    (raw_x_r),
    .lo     (cfg_x_min_r),
    .hi     (cfg_x_max_r),
    .res    (cfg_width_r),
    .status (lane_x_st)
  );

  tcs_lane u_lane_y (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (lane_start),
    .raw    (raw_y_r),
    .lo     (cfg_y_min_r),
    .hi     (cfg_y_max_r),
    .res    (cfg_height_r),
    .status (lane_y_st)
  );

  // merge: mirror Y, then filter
  always_comb begin
    if (cfg_rotate_r) begin
      y_rot = (cfg_height_r == '0) ? '0 : (cfg_height_r - 1'b1 - lane_y_st.coord);
    end else begin
      y_rot = lane_y_st.coord;
    end
    seed_x_w = WIDE_W'(lane_x_st.coord);
    seed_y_w = WIDE_W'(y_rot);
    sum_x    = (SUM_W'(smooth_x_r) << 1) + SUM_W'(smooth_x_r) + SUM_W'(seed_x_w);
    sum_y    = (SUM_W'(smooth_y_r) << 1) + SUM_W'(smooth_y_r) + SUM_W'(seed_y_w);
    filt_x_w = sum_x[SUM_W-1:2];
    filt_y_w = sum_y[SUM_W-1:2];
  end

  always_comb begin
    smooth_x_nxt = smooth_x_r;
    smooth_y_nxt = smooth_y_r;
    primed_nxt   = primed_r;
    if (merge_fire && en_r) begin
      if (!pressed_r) begin
        smooth_x_nxt = '0;
        smooth_y_nxt = '0;
        primed_nxt   = 1'b0;
      end else if (!primed_r) begin
        smooth_x_nxt = seed_x_w[COORD_BITS-1:0];
        smooth_y_nxt = seed_y_w[COORD_BITS-1:0];
        primed_nxt   = 1'b1;
      end else begin
        smooth_x_nxt = filt_x_w[COORD_BITS-1:0];
        smooth_y_nxt = filt_y_w[COORD_BITS-1:0];
      end
    end
    pos_x_w = WIDE_W'(smooth_x_nxt);
    pos_y_w = WIDE_W'(smooth_y_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (cfg_enable_r && in_pressed) ? S_START : S_MERGE;
        end
      end
      S_START: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (lane_x_st.done && lane_y_st.done) begin
          state_nxt = S_MERGE;
        end
      end
      S_MERGE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cfg_enable_r <= RST_ENABLE;
      cfg_rotate_r <= RST_ROTATE;
      cfg_x_min_r  <= RST_CAL_MIN;
      cfg_x_max_r  <= RST_CAL_MAX;
      cfg_y_min_r  <= RST_CAL_MIN;
      cfg_y_max_r  <= RST_CAL_MAX;
      cfg_width_r  <= RST_SCREEN_W;
      cfg_height_r <= RST_SCREEN_H;
      smooth_x_r   <= '0;
      smooth_y_r   <= '0;
      primed_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      smooth_x_r <= smooth_x_nxt;
      smooth_y_r <= smooth_y_nxt;
      primed_r   <= primed_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:    cfg_enable_r <= cfg_wdata[0];
          REG_ROTATE:    cfg_rotate_r <= cfg_wdata[0];
          REG_CAL_X_MIN: cfg_x_min_r  <= cfg_wdata[RAW_W-1:0];
          REG_CAL_X_MAX: cfg_x_max_r  <= cfg_wdata[RAW_W-1:0];
          REG_CAL_Y_MIN: cfg_y_min_r  <= cfg_wdata[RAW_W-1:0];
          REG_CAL_Y_MAX: cfg_y_max_r  <= cfg_wdata[RAW_W-1:0];
          REG_SCREEN_W:  cfg_width_r  <= cfg_wdata[RES_W-1:0];
          REG_SCREEN_H:  cfg_height_r <= cfg_wdata[RES_W-1:0];
          default: begin
          end
        endcase
      end
      if (merge_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      raw_x_r   <= in_raw_x;
      raw_y_r   <= in_raw_y;
      pressed_r <= in_pressed;
      en_r      <= cfg_enable_r;
    end
    if (merge_fire) begin
      if (en_r && pressed_r) begin
        out_tv_r <= 1'b1;
        out_x_r  <= pos_x_w[POS_W-1:0];
        out_y_r  <= pos_y_w[POS_W-1:0];
      end else begin
        out_tv_r <= 1'b0;
        out_x_r  <= '0;
        out_y_r  <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_touch_valid = out_tv_r;
  assign out_pos_x       = out_x_r;
  assign out_pos_y       = out_y_r;

  // both lanes run in lock step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    lane_x_st.done == lane_y_st.done)
    else $error("lane finish pulses out of step");

  // lanes only report while the sequencer waits on them
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    lane_x_st.done |-> state_r == S_DIV)
    else $error("lane finished outside the divide phase");

  // a no-touch result carries zero coordinates
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_touch_valid |-> out_pos_x == '0 && out_pos_y == '0)
    else $error("no-touch result with non-zero position");

  // one word at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in flight");

  // a released word on an enabled unit empties the filter
  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    merge_fire && en_r && !pressed_r |=> !primed_r && smooth_x_r == '0)
    else $error("filter not cleared on release");

endmodule

/* dv/tb_touch_coordinate_calibrate_smooth_unit.sv */
// ----------------------------------------------------------------------------
// tb_touch_coordinate_calibrate_smooth_unit: self-checking testbench
// Feeds touch samples (strokes, releases, noise) through the unit under many
// calibration settings with random idling on both channels, predicts every
// calibrated and smoothed point and checks each output word field by field.
// ----------------------------------------------------------------------------

typedef struct {
  logic                      touch_valid;
  logic [tcs_pkg::POS_W-1:0] pos_x;
  logic [tcs_pkg::POS_W-1:0] pos_y;
} touch_point_t;

typedef struct {
  logic                      enable;
  logic                      rotate;
  logic [tcs_pkg::RAW_W-1:0] x_min;
  logic [tcs_pkg::RAW_W-1:0] x_max;
  logic [tcs_pkg::RAW_W-1:0] y_min;
  logic [tcs_pkg::RAW_W-1:0] y_max;
  logic [tcs_pkg::RES_W-1:0] width;
  logic [tcs_pkg::RES_W-1:0] height;
} touch_cfg_t;

class touch_point_predictor;
  touch_cfg_t                regs;
  logic [tcs_pkg::POS_W-1:0] smooth_x;
  logic [tcs_pkg::POS_W-1:0] smooth_y;
  bit                        primed;
  touch_point_t              predicted_points[$];
  int                        errors;

  function new();
    regs.enable = tcs_pkg::RST_ENABLE;
    regs.rotate = tcs_pkg::RST_ROTATE;
    regs.x_min  = tcs_pkg::RST_CAL_MIN;
    regs.x_max  = tcs_pkg::RST_CAL_MAX;
    regs.y_min  = tcs_pkg::RST_CAL_MIN;
    regs.y_max  = tcs_pkg::RST_CAL_MAX;
    regs.width  = tcs_pkg::RST_SCREEN_W;
    regs.height = tcs_pkg::RST_SCREEN_H;
    smooth_x    = '0;
    smooth_y    = '0;
    primed      = 1'b0;
    errors      = 0;
  endfunction

  function void write_reg(logic [tcs_pkg::CFG_IDX_W-1:0] idx,
                          logic [tcs_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      tcs_pkg::REG_ENABLE:    regs.enable = val[0];
      tcs_pkg::REG_ROTATE:    regs.rotate = val[0];
      tcs_pkg::REG_CAL_X_MIN: regs.x_min  = val;
      tcs_pkg::REG_CAL_X_MAX: regs.x_max  = val;
      tcs_pkg::REG_CAL_Y_MIN: regs.y_min  = val;
      tcs_pkg::REG_CAL_Y_MAX: regs.y_max  = val;
      tcs_pkg::REG_SCREEN_W:  regs.width  = val;
      tcs_pkg::REG_SCREEN_H:  regs.height = val;
      default: ;
    endcase
  endfunction

  // inverse map from the calibration window, truncating division, then clamp
  function logic [11:0] calibrate_axis(logic [11:0] raw, logic [11:0] lo,
                                       logic [11:0] hi, logic [11:0] res);
    int span;
    int m;
    if (res == 0) return '0;
    span = int'(hi) - int'(lo);
    if (span == 0) m = 0;
    else m = (int'(raw) - int'(lo)) * (-int'(res)) / span + int'(res);
    if (m < 0) m = 0;
    else if (m >= int'(res)) m = int'(res) - 1;
    return m[11:0];
  endfunction

  function logic [11:0] blend(logic [11:0] old_v, logic [11:0] new_v);
    int s;
    s = (int'(old_v) * 3 + int'(new_v)) / 4;
    return s[11:0];
  endfunction

  function void take_sample(logic pressed, logic [11:0] raw_x, logic [11:0] raw_y);
    touch_point_t p;
    logic [11:0]  x;
    logic [11:0]  y;
    p.touch_valid = 1'b0;
    p.pos_x       = '0;
    p.pos_y       = '0;
    if (regs.enable) begin
      if (!pressed) begin
        smooth_x = '0;
        smooth_y = '0;
        primed   = 1'b0;
      end else begin
        x = calibrate_axis(raw_x, regs.x_min, regs.x_max, regs.width);
        y = calibrate_axis(raw_y, regs.y_min, regs.y_max, regs.height);
        if (regs.rotate) y = (regs.height == 0) ? 12'd0 : regs.height - 12'd1 - y;
        if (!primed) begin
          smooth_x = x;
          smooth_y = y;
          primed   = 1'b1;
        end else begin
          smooth_x = blend(smooth_x, x);
          smooth_y = blend(smooth_y, y);
        end
        p.touch_valid = 1'b1;
        p.pos_x       = smooth_x;
        p.pos_y       = smooth_y;
      end
    end
    predicted_points.push_back(p);
  endfunction

  function void check_point(logic tv, logic [11:0] px, logic [11:0] py);
    touch_point_t e;
    if (predicted_points.size() == 0) begin
      $display("%0t: unexpected word: touch_valid %0d pos_x %0d pos_y %0d",
               $time, tv, px, py);
      errors++;
      return;
    end
    e = predicted_points.pop_front();
    if (tv !== e.touch_valid) begin
      $display("%0t: touch_valid mismatch: expected %0d, actual %0d",
               $time, e.touch_valid, tv);
      errors++;
    end
    if (px !== e.pos_x) begin
      $display("%0t: pos_x mismatch: expected %0d, actual %0d", $time, e.pos_x, px);
      errors++;
    end
    if (py !== e.pos_y) begin
      $display("%0t: pos_y mismatch: expected %0d, actual %0d", $time, e.pos_y, py);
      errors++;
    end
  endfunction
endclass

module tb_touch_coordinate_calibrate_smooth_unit;
  import tcs_pkg::*;

  localparam int ITEMS       = 1500;
  localparam int LONG_HOLD   = 400;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_pressed = 1'b0;
  logic [RAW_W-1:0]      in_raw_x  = '0;
  logic [RAW_W-1:0]      in_raw_y  = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic                  out_touch_valid;
  logic [POS_W-1:0]      out_pos_x;
  logic [POS_W-1:0]      out_pos_y;

  touch_point_predictor calib = new();
  bit no_idle      = 1'b0;
  bit hold_off_req = 1'b0;
  int words_sent   = 0;
  int quiet_cycles = 0;

  touch_coordinate_calibrate_smooth_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_pressed      (in_pressed),
    .in_raw_x        (in_raw_x),
    .in_raw_y        (in_raw_y),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_touch_valid (out_touch_valid),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // both handshakes are observed here, plus the stall watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) calib.take_sample(in_pressed, in_raw_x, in_raw_y);
      if (out_valid && out_ready) calib.check_point(out_touch_valid, out_pos_x, out_pos_y);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 3);
  endfunction

  // receiver: random back-pressure per word, one long hold when asked
  initial begin
    int gap;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = draw_gap();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  task automatic send_word(input logic p, input logic [11:0] x, input logic [11:0] y);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pressed <= p;
    in_raw_x   <= x;
    in_raw_y   <= y;
    do @(posedge clk); while (in_ready !== 1'b1);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (calib.predicted_points.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    calib.write_reg(idx, val);
  endtask

  task automatic apply_settings(input touch_cfg_t s);
    write_reg(REG_ENABLE, {11'd0, s.enable});
    write_reg(REG_ROTATE, {11'd0, s.rotate});
    write_reg(REG_CAL_X_MIN, s.x_min);
    write_reg(REG_CAL_X_MAX, s.x_max);
    write_reg(REG_CAL_Y_MIN, s.y_min);
    write_reg(REG_CAL_Y_MAX, s.y_max);
    write_reg(REG_SCREEN_W, s.width);
    write_reg(REG_SCREEN_H, s.height);
    cfg_we <= 1'b0;
  endtask

  function automatic touch_cfg_t make_cfg(logic en, logic rot, logic [11:0] xl, logic [11:0] xh,
                                          logic [11:0] yl, logic [11:0] yh,
                                          logic [11:0] w, logic [11:0] h);
    touch_cfg_t s;
    s.enable = en;
    s.rotate = rot;
    s.x_min  = xl;
    s.x_max  = xh;
    s.y_min  = yl;
    s.y_max  = yh;
    s.width  = w;
    s.height = h;
    return s;
  endfunction

  // mostly a normal window, sometimes inverted, collapsed or at the extremes
  task automatic draw_window(output logic [11:0] lo, output logic [11:0] hi);
    case ($urandom_range(0, 7))
      4: begin
        lo = 12'($urandom_range(3400, 4095));
        hi = 12'($urandom_range(0, 600));
      end
      5: begin
        lo = 12'($urandom_range(0, 4095));
        hi = 12'($urandom_range(0, 4095));
      end
      6: begin
        lo = 12'($urandom_range(0, 4095));
        hi = lo;
      end
      7: begin
        lo = $urandom_range(0, 1) ? 12'd0 : 12'd4095;
        hi = ~lo;
      end
      default: begin
        lo = 12'($urandom_range(0, 600));
        hi = 12'($urandom_range(3400, 4095));
      end
    endcase
  endtask

  function automatic logic [11:0] draw_res();
    case ($urandom_range(0, 7))
      5:       return 12'd4095;
      6:       return 12'd1;
      7:       return 12'($urandom_range(0, 4095));
      default: return 12'($urandom_range(1, 1024));
    endcase
  endfunction

  task automatic random_settings(output touch_cfg_t s);
    s.enable = ($urandom_range(0, 7) != 0);
    s.rotate = 1'($urandom_range(0, 1));
    draw_window(s.x_min, s.x_max);
    draw_window(s.y_min, s.y_max);
    s.width  = draw_res();
    s.height = draw_res();
  endtask

  function automatic int start_coord();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic int drift(int c);
    int v;
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 4095);
    v = c + int'($urandom_range(0, 128)) - 64;
    if (v < 0) v = 0;
    else if (v > 4095) v = 4095;
    return v;
  endfunction

  // mostly strokes of pressed words ended by a release, with some noise
  task automatic run_phase(input int n_words);
    int first;
    int x;
    int y;
    int len;
    first = words_sent;
    while (words_sent - first < n_words) begin
      case ($urandom_range(0, 7))
        6: begin
          repeat ($urandom_range(1, 6))
            send_word(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                      12'($urandom_range(0, 4095)));
        end
        7: send_word(1'b0, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        default: begin
          len = $urandom_range(1, 16);
          x   = start_coord();
          y   = start_coord();
          repeat (len) begin
            send_word(1'b1, x[11:0], y[11:0]);
            x = drift(x);
            y = drift(y);
          end
          send_word(1'b0, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        end
      endcase
    end
    wait_drained();
  endtask

  initial begin
    touch_cfg_t s;
    int         phase_no;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: clamp edges, window edges, release and re-seed
    send_word(1'b1, 12'd0, 12'd0);
    send_word(1'b1, 12'd4095, 12'd4095);
    send_word(1'b0, 12'd4095, 12'd4095);
    send_word(1'b1, 12'd200, 12'd3900);
    send_word(1'b1, 12'd3900, 12'd200);
    send_word(1'b1, 12'd2050, 12'd2050);
    send_word(1'b0, 12'd0, 12'd0);
    send_word(1'b1, 12'd1234, 12'd2345);
    wait_drained();

    // disabled: no touch reported and the filter is held, even over a release
    apply_settings(make_cfg(1'b0, 1'b1, 12'd200, 12'd3900, 12'd200, 12'd3900,
                            12'd320, 12'd240));
    send_word(1'b1, 12'd100, 12'd100);
    send_word(1'b0, 12'd5, 12'd5);
    wait_drained();
    apply_settings(make_cfg(1'b1, 1'b1, 12'd200, 12'd3900, 12'd200, 12'd3900,
                            12'd320, 12'd240));
    send_word(1'b1, 12'd2050, 12'd2050);
    wait_drained();

    // collapsed windows on both axes, widest and narrowest screen
    apply_settings(make_cfg(1'b1, 1'b0, 12'd1000, 12'd1000, 12'd4095, 12'd4095,
                            12'd4095, 12'd1));
    send_word(1'b1, 12'd0, 12'd4095);
    send_word(1'b1, 12'd4095, 12'd0);
    wait_drained();

    // zero resolution on both axes with mirroring, inverted X window
    apply_settings(make_cfg(1'b1, 1'b1, 12'd4095, 12'd0, 12'd0, 12'd4095,
                            12'd0, 12'd0));
    send_word(1'b1, 12'd0, 12'd0);
    send_word(1'b1, 12'd4095, 12'd2000);
    wait_drained();

    apply_settings(make_cfg(1'b1, 1'b1, 12'd0, 12'd4095, 12'd0, 12'd4095,
                            12'd1, 12'd4095));
    send_word(1'b1, 12'd4095, 12'd0);
    send_word(1'b1, 12'd0, 12'd4095);
    send_word(1'b0, 12'd0, 12'd0);
    send_word(1'b1, 12'd2048, 12'd2048);
    wait_drained();

    phase_no = 0;
    while (words_sent < ITEMS) begin
      random_settings(s);
      apply_settings(s);
      no_idle = ($urandom_range(0, 3) == 0);
      // one phase runs against a long output stall so the unit backs up
      if (phase_no == 2) hold_off_req = 1'b1;
      run_phase((phase_no == 2) ? 60 : $urandom_range(20, 80));
      phase_no++;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (calib.errors == 0 && calib.predicted_points.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
